// File: rtl/tstq_pkg.sv
// shared types and constants for the sorted tick timer queue
`default_nettype none

package tstq_pkg;

	localparam int DEF_NUM_TIMERS = 16;
	localparam int TID_W          = 4;
	localparam int TICK_W         = 32;
	localparam int KIND_W         = 2;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 8;

	// request kinds carried on the slave tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_ARM    = 2'd1,
		KIND_CANCEL = 2'd2
	} kind_t;

	// result kinds carried on the master tuser
	typedef enum logic {
		REP_EXPIRED = 1'b0,
		REP_CANCEL  = 1'b1
	} rep_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RM,
		ST_INS,
		ST_TRD,
		ST_TCMP,
		ST_TFIN,
		ST_CREP
	} st_t;

	// operand selection of the shared comparator
	typedef enum logic {
		CMP_INS,
		CMP_TICK
	} cmp_sel_t;

	typedef struct packed {
		cmp_sel_t sel;
	} alu_ctl_t;

	typedef struct packed {
		logic lt;
		logic id_hit;
	} alu_sts_t;

	// one queue slot: timer identifier and its expiry tick
	typedef struct packed {
		logic [TID_W-1:0]  id;
		logic [TICK_W-1:0] exp;
	} ent_t;

endpackage

`default_nettype wire

// File: rtl/sorted_tick_timer_queue.sv
// top level of the sorted tick timer queue
// tick: pops each expired timer from the head, and can wait on m_axis_tready
// arm: runs the remove and insert walks over the queue ram, one slot per cycle
// through the single read port
// cancel: runs the remove walk; one request in flight, results leave via a register
// arst_n clears count, length, head and pending flags; the ram needs no clearing
`default_nettype none

module sorted_tick_timer_queue
	import tstq_pkg::*;
#(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// request channel
	input  wire logic                 s_axis_tvalid,
	output      logic                 s_axis_tready,
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // timer_id[3:0], delay[35:4], zero pad
	input  wire logic [KIND_W-1:0]    s_axis_tuser,  // kind[1:0]
	// result channel
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output      logic [M_TDATA_W-1:0] m_axis_tdata,  // timer_id_res[3:0], found[4], zero pad
	output      logic                 m_axis_tuser,  // report[0]
	output      logic                 m_axis_tlast
);

	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam int LEN_W = $clog2(NUM_TIMERS + 1);

	// request fields
	logic [TID_W-1:0]  in_id;
	logic [TICK_W-1:0] in_delay;
	logic [IDX_W-1:0]  in_idx;
	logic              in_ok;

	// sequencer state
	st_t               st_q, st_d;
	logic [TICK_W-1:0] cnt_q, cnt_d;     // tick count, advanced by each tick request
	logic [LEN_W-1:0]  len_q, len_d;     // number of pending timers
	logic [IDX_W-1:0]  hd_q, hd_d;       // ring slot of the earliest timer
	logic [NUM_TIMERS-1:0] pend_q, pend_d;
	logic [LEN_W-1:0]  ri_q, ri_d;       // walk index of the next ram read
	logic [LEN_W-1:0]  di_q, di_d;       // walk index belonging to the read data
	logic              dv_q, dv_d;       // read data valid this cycle
	logic              fnd_q, fnd_d;     // timer found during the remove walk
	logic              arm_q, arm_d;     // remove walk is followed by an insert
	logic              have_q, have_d;   // an expired timer waits for its last flag
	logic [TID_W-1:0]  cand_q, cand_d;
	logic [TID_W-1:0]  id_q, id_d;
	logic [TICK_W-1:0] when_q, when_d;
	logic [IDX_W-1:0]  id_idx_q;

	// ram and shared unit hookup
	logic              re, we;
	logic [IDX_W-1:0]  raddr, waddr;
	logic [LEN_W-1:0]  ridx, widx;
	ent_t              wdata, rdata, new_ent;
	alu_ctl_t          ctl;
	alu_sts_t          sts;

	// result register
	logic              out_free;
	logic              ld;
	rep_t              ld_rep;
	logic [TID_W-1:0]  ld_id;
	logic              ld_found;
	logic              ld_last;
	logic              m_valid_q;
	rep_t              m_rep_q;
	logic [TID_W-1:0]  m_id_q;
	logic              m_found_q;
	logic              m_last_q;

	assign in_id    = s_axis_tdata[TID_W-1:0];
	assign in_delay = s_axis_tdata[TID_W+TICK_W-1:TID_W];
	assign in_idx   = IDX_W'(in_id);
	assign in_ok    = 32'(in_id) < 32'(NUM_TIMERS);
	assign id_idx_q = IDX_W'(id_q);
	assign new_ent  = '{id: id_q, exp: when_q};
	assign out_free = !m_valid_q || m_axis_tready;

	tstq_ram #(
		.DEPTH (NUM_TIMERS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	tstq_alu #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_alu (
		.ctl      (ctl),
		.hd       (hd_q),
		.ridx     (ridx),
		.widx     (widx),
		.when_val (when_q),
		.cnt      (cnt_q),
		.id       (id_q),
		.rdata    (rdata),
		.raddr    (raddr),
		.waddr    (waddr),
		.sts      (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d          = st_q;
		cnt_d         = cnt_q;
		len_d         = len_q;
		hd_d          = hd_q;
		pend_d        = pend_q;
		ri_d          = ri_q;
		di_d          = di_q;
		dv_d          = 1'b0;
		fnd_d         = fnd_q;
		arm_d         = arm_q;
		have_d        = have_q;
		cand_d        = cand_q;
		id_d          = id_q;
		when_d        = when_q;
		re            = 1'b0;
		we            = 1'b0;
		ridx          = '0;
		widx          = '0;
		wdata         = new_ent;
		ctl.sel       = CMP_INS;
		ld            = 1'b0;
		ld_rep        = REP_EXPIRED;
		ld_id         = cand_q;
		ld_found      = 1'b0;
		ld_last       = 1'b0;
		s_axis_tready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					id_d = in_id;
					case (s_axis_tuser)
						KIND_TICK: begin
							cnt_d  = cnt_q + 32'd1;
							have_d = 1'b0;
							st_d   = ST_TRD;
						end
						KIND_ARM: begin
							if (in_ok) begin
								when_d = cnt_q + in_delay;
								arm_d  = 1'b1;
								fnd_d  = 1'b0;
								ri_d   = pend_q[in_idx] ? '0 : len_q;
								st_d   = pend_q[in_idx] ? ST_RM : ST_INS;
							end
						end
						KIND_CANCEL: begin
							arm_d = 1'b0;
							fnd_d = 1'b0;
							ri_d  = '0;
							st_d  = (in_ok && pend_q[in_idx]) ? ST_RM : ST_CREP;
						end
						default: begin
						end
					endcase
				end
			end
			// walk up the queue, closing the gap behind the matching slot
			ST_RM: begin
				if (ri_q < len_q) begin
					re   = 1'b1;
					ridx = ri_q;
					ri_d = ri_q + LEN_W'(1);
					dv_d = 1'b1;
					di_d = ri_q;
				end
				if (dv_q) begin
					if (fnd_q) begin
						we    = 1'b1;
						widx  = di_q - LEN_W'(1);
						wdata = rdata;
					end else if (sts.id_hit) begin
						fnd_d = 1'b1;
					end
				end else if (ri_q == len_q) begin
					len_d            = len_q - LEN_W'(fnd_q);
					pend_d[id_idx_q] = 1'b0;
					ri_d             = len_q - LEN_W'(fnd_q);
					st_d             = arm_q ? ST_INS : ST_CREP;
				end
			end
			// walk down from the tail, shifting later expiries up one slot
			ST_INS: begin
				if (ri_q != '0) begin
					re   = 1'b1;
					ridx = ri_q - LEN_W'(1);
					ri_d = ri_q - LEN_W'(1);
					dv_d = 1'b1;
					di_d = ri_q;
				end
				if (dv_q) begin
					we   = 1'b1;
					widx = di_q;
					if (sts.lt) begin
						wdata = rdata;
					end else begin
						len_d            = len_q + LEN_W'(1);
						pend_d[id_idx_q] = 1'b1;
						st_d             = ST_IDLE;
					end
				end else if (ri_q == '0) begin
					// new timer becomes the head
					we               = 1'b1;
					widx             = '0;
					len_d            = len_q + LEN_W'(1);
					pend_d[id_idx_q] = 1'b1;
					st_d             = ST_IDLE;
				end
			end
			ST_TRD: begin
				if (len_q != '0) begin
					re   = 1'b1;
					ridx = '0;
					st_d = ST_TCMP;
				end else begin
					st_d = ST_TFIN;
				end
			end
			// pop the head if expired; the previous pop is sent as not last
			ST_TCMP: begin
				ctl.sel = CMP_TICK;
				widx    = LEN_W'(1);
				if (sts.lt) begin
					if (!have_q || out_free) begin
						if (have_q) begin
							ld = 1'b1;
						end
						cand_d                    = rdata.id;
						have_d                    = 1'b1;
						hd_d                      = waddr;
						len_d                     = len_q - LEN_W'(1);
						pend_d[IDX_W'(rdata.id)]  = 1'b0;
						st_d                      = ST_TRD;
					end
				end else begin
					st_d = ST_TFIN;
				end
			end
			ST_TFIN: begin
				if (!have_q) begin
					st_d = ST_IDLE;
				end else if (out_free) begin
					ld      = 1'b1;
					ld_last = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			ST_CREP: begin
				if (out_free) begin
					ld       = 1'b1;
					ld_rep   = REP_CANCEL;
					ld_id    = id_q;
					ld_found = fnd_q;
					ld_last  = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			len_q     <= '0;
			hd_q      <= '0;
			pend_q    <= '0;
			dv_q      <= 1'b0;
			have_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			len_q  <= len_d;
			hd_q   <= hd_d;
			pend_q <= pend_d;
			dv_q   <= dv_d;
			have_q <= have_d;
			if (ld) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		ri_q   <= ri_d;
		di_q   <= di_d;
		fnd_q  <= fnd_d;
		arm_q  <= arm_d;
		cand_q <= cand_d;
		id_q   <= id_d;
		when_q <= when_d;
		if (ld) begin
			m_rep_q   <= ld_rep;
			m_id_q    <= ld_id;
			m_found_q <= ld_found;
			m_last_q  <= ld_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W-TID_W-1){1'b0}}, m_found_q, m_id_q};
	assign m_axis_tuser  = m_rep_q;
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// File: rtl/tstq_ram.sv
// queue storage, one write port and one registered read port
`default_nettype none

module tstq_ram
	import tstq_pkg::*;
#(
	parameter int DEPTH = DEF_NUM_TIMERS,
	parameter int AW    = $clog2(DEF_NUM_TIMERS)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire ent_t          wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output      ent_t          rdata
);

	ent_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/tstq_alu.sv
// shared expiry comparator and circular slot address generation
`default_nettype none

module tstq_alu
	import tstq_pkg::*;
#(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS,
	localparam int IDX_W = $clog2(NUM_TIMERS),
	localparam int LEN_W = $clog2(NUM_TIMERS + 1)
) (
	input  wire alu_ctl_t          ctl,
	input  wire logic [IDX_W-1:0]  hd,
	input  wire logic [LEN_W-1:0]  ridx,
	input  wire logic [LEN_W-1:0]  widx,
	input  wire logic [TICK_W-1:0] when_val,
	input  wire logic [TICK_W-1:0] cnt,
	input  wire logic [TID_W-1:0]  id,
	input  wire ent_t              rdata,
	output      logic [IDX_W-1:0]  raddr,
	output      logic [IDX_W-1:0]  waddr,
	output      alu_sts_t          sts
);

	localparam int SW = LEN_W + 1;
	localparam logic [SW-1:0] DEPTH_C = SW'(NUM_TIMERS);

	logic [SW-1:0]     rsum;
	logic [SW-1:0]     wsum;
	logic [TICK_W-1:0] op_a;
	logic [TICK_W-1:0] op_b;

	// head plus logical index, folded back once into the ring
	always_comb begin
		rsum = SW'(hd) + SW'(ridx);
		wsum = SW'(hd) + SW'(widx);
		if (rsum >= DEPTH_C) begin
			rsum = rsum - DEPTH_C;
		end
		if (wsum >= DEPTH_C) begin
			wsum = wsum - DEPTH_C;
		end
		raddr = IDX_W'(rsum);
		waddr = IDX_W'(wsum);
	end

	// insert: new expiry below slot expiry; tick: slot expiry below count
	always_comb begin
		case (ctl.sel)
			CMP_TICK: begin
				op_a = rdata.exp;
				op_b = cnt;
			end
			default: begin
				op_a = when_val;
				op_b = rdata.exp;
			end
		endcase
		sts.lt     = op_a < op_b;
		sts.id_hit = rdata.id == id;
	end

endmodule

`default_nettype wire

// File: rtl/tstq_chk.sv
// port checker for the sorted tick timer queue and its bind
`default_nettype none

module tstq_chk
	import tstq_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_axis_tvalid,
	input wire logic                 s_axis_tready,
	input wire logic [KIND_W-1:0]    s_axis_tuser,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [M_TDATA_W-1:0] m_axis_tdata,
	input wire logic                 m_axis_tuser,
	input wire logic                 m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("result changed while stalled");

	// a cancel reply is always the only result of its request
	a_cancel_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == REP_CANCEL) |-> m_axis_tlast)
		else $error("cancel reply without last");

	// expiry reports never carry found
	a_exp_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == REP_EXPIRED) |-> !m_axis_tdata[TID_W])
		else $error("expiry report with found set");

	// a tick keeps the block busy while the head is checked
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_TICK) |=> !s_axis_tready)
		else $error("tick request did not start the head check");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:TID_W+1] == '0))
		else $error("nonzero padding in result");

endmodule

bind sorted_tick_timer_queue tstq_chk u_tstq_chk (.*);

`default_nettype wire

// File: bench/sorted_tick_timer_queue_checker.sv
`timescale 1ns / 1ps
// checker that mirrors the timer queue and compares the result stream against it
module sorted_tick_timer_queue_checker
	import tstq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	input  wire logic                 s_axis_tready,
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // timer_id[3:0], delay[35:4], zero pad
	input  wire logic [KIND_W-1:0]    s_axis_tuser,  // kind[1:0]
	input  wire logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	input  wire logic [M_TDATA_W-1:0] m_axis_tdata,  // timer_id_res[3:0], found[4], zero pad
	input  wire logic                 m_axis_tuser,  // report[0]
	input  wire logic                 m_axis_tlast,
	output int                        mismatches,
	output int                        reports_due
);

	localparam int NT         = DEF_NUM_TIMERS;
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		rep_t             report;
		logic [TID_W-1:0] id;
		logic             found;
		logic             last;
	} timer_report_t;

	timer_report_t     awaited_reports[$];
	logic [TICK_W-1:0] tick_now = '0;
	logic [TID_W-1:0]  fire_order[NT];
	logic [TICK_W-1:0] fire_tick[NT];
	bit                armed[NT];
	int                armed_count = 0;

	function automatic void drop_slot(input int pos);
		int i;
		for (i = pos; i + 1 < armed_count; i++)
			fire_order[i] = fire_order[i + 1];
		armed_count--;
	endfunction

	function automatic bit disarm(input logic [TID_W-1:0] id);
		int i;
		bit hit;
		hit = 1'b0;
		if (armed[id]) begin
			for (i = 0; i < armed_count && !hit; i++) begin
				if (fire_order[i] == id) begin
					drop_slot(i);
					hit = 1'b1;
				end
			end
			armed[id] = 1'b0;
		end
		return hit;
	endfunction

	// re-arming drops the old slot first; ties go behind existing timers
	function automatic void arm_timer(input logic [TID_W-1:0] id, input logic [TICK_W-1:0] delay);
		logic [TICK_W-1:0] due;
		int                pos;
		int                i;
		void'(disarm(id));
		due = tick_now + delay;
		pos = 0;
		while (pos < armed_count && fire_tick[fire_order[pos]] <= due)
			pos++;
		for (i = armed_count; i > pos; i--)
			fire_order[i] = fire_order[i - 1];
		fire_order[pos] = id;
		fire_tick[id]   = due;
		armed[id]       = 1'b1;
		armed_count++;
	endfunction

	function automatic void advance_tick();
		logic [TID_W-1:0] head;
		int               fired;
		bit               more;
		tick_now = tick_now + 1'b1;
		fired    = 0;
		more     = armed_count > 0 && fire_tick[fire_order[0]] < tick_now;
		while (more) begin
			head = fire_order[0];
			drop_slot(0);
			armed[head] = 1'b0;
			fired++;
			more = armed_count > 0 && fired < NT && fire_tick[fire_order[0]] < tick_now;
			awaited_reports.push_back('{REP_EXPIRED, head, 1'b0, !more});
		end
	endfunction

	function automatic void log_failure(input string msg);
		if (mismatches < MAX_SHOWN)
			$display("%0t: %s", $realtime, msg);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_report_t want;
		timer_report_t got;
		logic          found;
		if (!arst_n) begin
			tick_now    = '0;
			armed       = '{default: 1'b0};
			armed_count = 0;
			awaited_reports.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					KIND_TICK: advance_tick();
					KIND_ARM: arm_timer(s_axis_tdata[TID_W-1:0], s_axis_tdata[TID_W +: TICK_W]);
					KIND_CANCEL: begin
						found = disarm(s_axis_tdata[TID_W-1:0]);
						awaited_reports.push_back('{REP_CANCEL, s_axis_tdata[TID_W-1:0], found, 1'b1});
					end
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{rep_t'(m_axis_tuser), m_axis_tdata[TID_W-1:0], m_axis_tdata[TID_W],
					m_axis_tlast};
				if (awaited_reports.size() == 0) begin
					log_failure($sformatf("unexpected result report=%0d id=%0d found=%0d last=%0d",
						got.report, got.id, got.found, got.last));
				end else begin
					want = awaited_reports.pop_front();
					if (got != want)
						log_failure($sformatf({"mismatch: expected report=%0d id=%0d found=%0d ",
							"last=%0d, got report=%0d id=%0d found=%0d last=%0d"},
							want.report, want.id, want.found, want.last,
							got.report, got.id, got.found, got.last));
				end
			end
		end
		reports_due = awaited_reports.size();
	end

endmodule

// File: bench/sorted_tick_timer_queue_tb.sv
`timescale 1ns / 1ps
// testbench top: stimulus, flow control and verdict for the sorted tick timer queue
module sorted_tick_timer_queue_tb;
	import tstq_pkg::*;

	localparam int NUM_TIMERS      = DEF_NUM_TIMERS;
	// the package has no name for the spare kind code, which the block must ignore
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int PHASE_ITEMS     = 95;
	localparam int PRESSURE_ITEMS  = 30;
	localparam int HOLD_OFF_CYCLES = 400;
	// an arm walk gives no result, so wait past it
	localparam int DRAIN_CYCLES    = 2 * NUM_TIMERS + 30;
	// worst quiet stretch is the hold-off plus one arm walk; keep a wide margin
	localparam int WATCHDOG_LIMIT  = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // timer_id[3:0], delay[35:4], zero pad
	logic [KIND_W-1:0]    s_axis_tuser = '0;  // kind[1:0]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;       // timer_id_res[3:0], found[4], zero pad
	logic                 m_axis_tuser;       // report[0]
	logic                 m_axis_tlast;

	int mismatches;
	int reports_due;

	// flow control knobs, percent of cycles spent idle or stalled
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;
	int quiet_cycles   = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	sorted_tick_timer_queue #(
		.NUM_TIMERS(NUM_TIMERS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	sorted_tick_timer_queue_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.mismatches   (mismatches),
		.reports_due  (reports_due)
	);

	// result side: random stalls, or a long hold-off counted here once asked for
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
			end
		end
	end

	// watchdog: any cycle without a handshake on either side counts as quiet
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// offer one request, with random idle cycles ahead of it, and wait for its handshake
	// valid stays high straight into the next request when no idle cycle is drawn
	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] id,
		input logic [TICK_W-1:0] delay);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {{(S_TDATA_W - TICK_W - TID_W){1'b0}}, delay, id};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
	endtask

	// mostly small delays so timers actually fire; a few full-range ones for the upper bits
	task automatic random_request();
		int                roll;
		logic [KIND_W-1:0] kind;
		logic [TICK_W-1:0] delay;
		roll = $urandom_range(0, 99);
		if (roll < 38)
			kind = KIND_TICK;
		else if (roll < 74)
			kind = KIND_ARM;
		else if (roll < 97)
			kind = KIND_CANCEL;
		else
			kind = KIND_UNUSED;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			delay = $urandom_range(0, 12);
		else if (roll < 85)
			delay = $urandom_range(0, 300);
		else
			delay = $urandom;
		send_request(kind, TID_W'($urandom_range(0, NUM_TIMERS - 1)), delay);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		int n;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (n = 0; n < count; n++)
			random_request();
	endtask

	initial begin
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, spare kind, extreme delays, ties, re-arm, cancel hit and miss
		send_request(KIND_TICK, 4'd0, '0);                    // tick with nothing armed
		send_request(KIND_CANCEL, 4'd0, '0);                  // cancel of an idle slot
		send_request(KIND_UNUSED, 4'd15, '1);                 // spare kind is dropped
		send_request(KIND_ARM, 4'd15, 32'hFFFF_FFFF);         // expiry wraps behind the count
		send_request(KIND_ARM, 4'd0, 32'd0);
		send_request(KIND_ARM, 4'd5, 32'd3);
		send_request(KIND_ARM, 4'd6, 32'd3);                  // same expiry, goes behind 5
		send_request(KIND_ARM, 4'd7, 32'd3);
		send_request(KIND_ARM, 4'd5, 32'd3);                  // re-arm moves 5 behind 7
		send_request(KIND_CANCEL, 4'd6, '0);                  // found
		send_request(KIND_CANCEL, 4'd6, '0);                  // already gone
		send_request(KIND_ARM, 4'd9, 32'h7FFF_FFFF);
		send_request(KIND_ARM, 4'd10, 32'hAAAA_AAAA);
		send_request(KIND_ARM, 4'd12, 32'h5555_5555);
		send_request(KIND_TICK, 4'd0, '0);                    // pops the wrapped and zero delays
		send_request(KIND_TICK, 4'd0, '0);
		send_request(KIND_TICK, 4'd0, '0);
		send_request(KIND_TICK, 4'd0, '0);
		send_request(KIND_TICK, 4'd0, '0);                    // pops nothing; the tied group fired on the previous tick
		send_request(KIND_CANCEL, 4'd9, '0);
		send_request(KIND_CANCEL, 4'd10, '0);
		send_request(KIND_CANCEL, 4'd15, '0);                 // already expired

		run_phase(0, 0, PHASE_ITEMS);
		run_phase(81, 0, PHASE_ITEMS);
		run_phase(0, 81, PHASE_ITEMS);
		run_phase(11, 11, PHASE_ITEMS);

		// fill every slot, then hold the result side off so ticks back up into the input
		send_idle_pct  = 0;
		recv_stall_pct = 11;
		for (i = 0; i < NUM_TIMERS; i++)
			send_request(KIND_ARM, TID_W'(i), TICK_W'($urandom_range(0, 1)));
		hold_req = 1'b1;
		send_request(KIND_TICK, 4'd0, '0);
		send_request(KIND_TICK, 4'd0, '0);
		send_request(KIND_TICK, 4'd0, '0);
		run_phase(0, 11, PRESSURE_ITEMS);

		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && reports_due == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
